// File: rtl/w2s_pkg.sv
package w2s_pkg;

  // Operation codes carried in the op field of an input transaction.
  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_PROJECT = 1'b1;

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_HALF_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_HALF_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_W_MIN       = 2'd2;
  localparam int CFG_DATA_W = 31;

  // Field widths.
  localparam int HALF_W     = 15;
  localparam int WMIN_W     = 31;
  localparam int COEF_IDX_W = 4;
  localparam int WORD_W     = 32;

  // Matrix store: three rows of four words.
  localparam int MATRIX_DEPTH = 12;

  // Reset values of the configuration registers.
  localparam logic [HALF_W-1:0] HALF_WIDTH_RESET  = 15'd960;
  localparam logic [HALF_W-1:0] HALF_HEIGHT_RESET = 15'd540;
  localparam logic [WMIN_W-1:0] W_MIN_RESET       = 31'd1677722;

endpackage

// File: rtl/w2s_if.sv
// Input channel: one transaction loads a matrix word or projects a point.
interface w2s_in_if
  import w2s_pkg::*;
  ();
  logic                         valid;
  logic                         ready;
  logic                         op;
  logic        [COEF_IDX_W-1:0] coef_index;
  logic signed [WORD_W-1:0]     coef_value;
  logic signed [WORD_W-1:0]     point_x;
  logic signed [WORD_W-1:0]     point_y;
  logic signed [WORD_W-1:0]     point_z;

  modport source (output valid, op, coef_index, coef_value, point_x, point_y, point_z,
                  input ready);
  modport sink   (input valid, op, coef_index, coef_value, point_x, point_y, point_z,
                  output ready);
endinterface

// Output channel: one transaction per projected point.
interface w2s_out_if
  import w2s_pkg::*;
  ();
  logic                     valid;
  logic                     ready;
  logic                     visible;
  logic signed [WORD_W-1:0] screen_x;
  logic signed [WORD_W-1:0] screen_y;

  modport source (output valid, visible, screen_x, screen_y, input ready);
  modport sink   (input valid, visible, screen_x, screen_y, output ready);
endinterface

// File: rtl/world_to_screen_projection.sv
// An accepted projection passes through the input register, six arithmetic stages,
// twenty divider stages at two quotient bits each and the output register.
// Throughput: one transaction per cycle while the skid register is empty.
// A matrix load gives no result. The whole pipeline advances together; a skid register
// behind the output register lets one more result in while the output is stalled.
// Reset (rst, synchronous) clears all valid bits, zeroes the matrix and loads defaults.
module world_to_screen_projection
  import w2s_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  w2s_in_if.sink                 point,
  w2s_out_if.source              result
);

  localparam int PROD_W     = 2 * WORD_W - 8;      // product after the floor shift
  localparam int SUM_W      = PROD_W + 2;          // dot product
  localparam int POS_W      = SUM_W - 1;           // positive w
  localparam int SCALE_W    = HALF_W + 8;          // half size in Q.8
  localparam int LO_W       = 32;
  localparam int HI_W       = SUM_W - LO_W;
  localparam int NUM_W      = SUM_W + SCALE_W;     // dividend
  localparam int Q_W        = 40;                  // quotient bits below saturation
  localparam int REM_W      = SUM_W;
  localparam int DIV_STEPS  = 2;
  localparam int DIV_STAGES = Q_W / DIV_STEPS;
  localparam int OFF_W      = Q_W + 2;
  localparam int RES_W      = OFF_W + 1;

  typedef struct packed {
    logic               vis;
    logic               neg_x;
    logic               neg_y;
    logic               sat_x;
    logic               sat_y;
    logic [POS_W-1:0]   w;
    logic [REM_W-1:0]   rem_x;
    logic [REM_W-1:0]   rem_y;
    logic [Q_W-1:0]     quo_x;
    logic [Q_W-1:0]     quo_y;
    logic [Q_W-1:0]     low_x;
    logic [Q_W-1:0]     low_y;
  } div_t;

  typedef struct packed {
    logic               visible;
    logic [WORD_W-1:0]  screen_x;
    logic [WORD_W-1:0]  screen_y;
  } res_t;

  // Configuration registers and matrix store.
  logic [HALF_W-1:0]        half_width;
  logic [HALF_W-1:0]        half_height;
  logic [WMIN_W-1:0]        w_min;
  logic signed [WORD_W-1:0] matrix [MATRIX_DEPTH];

  // Pipeline registers.
  logic                          adv;
  logic                          v0, v1, v2, v3, v4, v5;
  logic                          op0;
  logic [COEF_IDX_W-1:0]         idx0;
  logic signed [WORD_W-1:0]      coef0;
  logic signed [WORD_W-1:0]      coord0 [3];
  logic signed [PROD_W-1:0]      prod1 [9];
  logic signed [WORD_W-1:0]      bias1 [3];
  logic signed [SUM_W-1:0]       dot2 [3];
  logic                          vis3, neg_x3, neg_y3;
  logic [POS_W-1:0]              w3;
  logic [SUM_W-1:0]              mag_x3, mag_y3;
  logic                          vis4, neg_x4, neg_y4;
  logic [POS_W-1:0]              w4;
  logic [LO_W+SCALE_W-1:0]       plo_x4, plo_y4;
  logic [HI_W+SCALE_W-1:0]       phi_x4, phi_y4;
  logic                          vis5, neg_x5, neg_y5;
  logic [POS_W-1:0]              w5;
  logic [NUM_W-1:0]              num_x5, num_y5;
  logic                          dv [DIV_STAGES+1];
  div_t                          ds [DIV_STAGES+1];
  div_t                          ds_next [DIV_STAGES];

  // Output side.
  logic out_valid, skid_valid;
  res_t out_data, skid_data, res;

  logic [SCALE_W-1:0] scale_x, scale_y;

  assign adv         = !skid_valid;
  assign point.ready = adv;
  assign scale_x     = {half_width, 8'd0};
  assign scale_y     = {half_height, 8'd0};

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      half_width  <= HALF_WIDTH_RESET;
      half_height <= HALF_HEIGHT_RESET;
      w_min       <= W_MIN_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_HALF_WIDTH:  half_width  <= cfg_data[HALF_W-1:0];
        CFG_HALF_HEIGHT: half_height <= cfg_data[HALF_W-1:0];
        CFG_W_MIN:       w_min       <= cfg_data[WMIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Matrix words are written as a load leaves the input register, so every projection
  // behind it sees the new word.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MATRIX_DEPTH; i++) matrix[i] <= '0;
    end else if (adv && v0 && op0 == OP_LOAD && idx0 < COEF_IDX_W'(MATRIX_DEPTH)) begin
      matrix[idx0] <= coef0;
    end
  end

  // Valid bits of the arithmetic stages; loads drop out after the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0; v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0;
    end else if (adv) begin
      v0 <= point.valid;
      v1 <= v0 && op0 == OP_PROJECT;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (adv) begin
      op0       <= point.op;
      idx0      <= point.coef_index;
      coef0     <= point.coef_value;
      coord0[0] <= point.point_x;
      coord0[1] <= point.point_y;
      coord0[2] <= point.point_z;
    end
  end

  // Stage 1: nine products, each shifted down by 8 with rounding toward minus infinity.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod1[r*3+c] <= PROD_W'((2*WORD_W)'(matrix[r*4+c] * coord0[c]) >>> 8);
        end
        bias1[r] <= matrix[r*4+3];
      end
    end
  end

  // Stage 2: the three dot products (clip x, clip y, w).
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        dot2[r] <= SUM_W'(prod1[r*3]) + SUM_W'(prod1[r*3+1]) + SUM_W'(prod1[r*3+2])
                 + SUM_W'(bias1[r]);
      end
    end
  end

  // Stage 3: visibility test and magnitudes of the clip coordinates.
  always_ff @(posedge clk) begin
    if (adv) begin
      vis3   <= dot2[2] > 0 && dot2[2] >= $signed({{(SUM_W-WMIN_W){1'b0}}, w_min});
      w3     <= dot2[2][POS_W-1:0];
      neg_x3 <= dot2[0][SUM_W-1];
      neg_y3 <= dot2[1][SUM_W-1];
      mag_x3 <= dot2[0][SUM_W-1] ? SUM_W'(-dot2[0]) : dot2[0];
      mag_y3 <= dot2[1][SUM_W-1] ? SUM_W'(-dot2[1]) : dot2[1];
    end
  end

  // Stage 4: magnitude times half size, in two partial products each.
  always_ff @(posedge clk) begin
    if (adv) begin
      vis4   <= vis3;
      w4     <= w3;
      neg_x4 <= neg_x3;
      neg_y4 <= neg_y3;
      plo_x4 <= mag_x3[LO_W-1:0] * scale_x;
      phi_x4 <= mag_x3[SUM_W-1:LO_W] * scale_x;
      plo_y4 <= mag_y3[LO_W-1:0] * scale_y;
      phi_y4 <= mag_y3[SUM_W-1:LO_W] * scale_y;
    end
  end

  // Stage 5: the dividends.
  always_ff @(posedge clk) begin
    if (adv) begin
      vis5   <= vis4;
      w5     <= w4;
      neg_x5 <= neg_x4;
      neg_y5 <= neg_y4;
      num_x5 <= NUM_W'(plo_x4) + {phi_x4, {LO_W{1'b0}}};
      num_y5 <= NUM_W'(plo_y4) + {phi_y4, {LO_W{1'b0}}};
    end
  end

  // Stage 6: saturation check (quotient of 2^40 or more) and divider set-up.
  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (adv) begin
      dv[0] <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ds[0].vis   <= vis5;
      ds[0].neg_x <= neg_x5;
      ds[0].neg_y <= neg_y5;
      ds[0].w     <= w5;
      ds[0].sat_x <= (POS_W+Q_W)'(num_x5) >= {w5, {Q_W{1'b0}}};
      ds[0].sat_y <= (POS_W+Q_W)'(num_y5) >= {w5, {Q_W{1'b0}}};
      ds[0].rem_x <= REM_W'(num_x5[NUM_W-1:Q_W]);
      ds[0].rem_y <= REM_W'(num_y5[NUM_W-1:Q_W]);
      ds[0].quo_x <= '0;
      ds[0].quo_y <= '0;
      ds[0].low_x <= num_x5[Q_W-1:0];
      ds[0].low_y <= num_y5[Q_W-1:0];
    end
  end

  // Restoring division, two quotient bits per stage for both coordinates.
  function automatic div_t div_step(input div_t s);
    div_t                d;
    logic [REM_W-1:0]    t_x;
    logic [REM_W-1:0]    t_y;
    logic [REM_W-1:0]    den;
    d   = s;
    den = {1'b0, s.w};
    for (int k = 0; k < DIV_STEPS; k++) begin
      t_x     = {d.rem_x[REM_W-2:0], d.low_x[Q_W-1]};
      t_y     = {d.rem_y[REM_W-2:0], d.low_y[Q_W-1]};
      d.low_x = {d.low_x[Q_W-2:0], 1'b0};
      d.low_y = {d.low_y[Q_W-2:0], 1'b0};
      if (t_x >= den) begin
        d.rem_x = t_x - den;
        d.quo_x = {d.quo_x[Q_W-2:0], 1'b1};
      end else begin
        d.rem_x = t_x;
        d.quo_x = {d.quo_x[Q_W-2:0], 1'b0};
      end
      if (t_y >= den) begin
        d.rem_y = t_y - den;
        d.quo_y = {d.quo_y[Q_W-2:0], 1'b1};
      end else begin
        d.rem_y = t_y;
        d.quo_y = {d.quo_y[Q_W-2:0], 1'b0};
      end
    end
    return d;
  endfunction

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    always_comb begin
      ds_next[g] = div_step(ds[g]);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[g+1] <= 1'b0;
      end else if (adv) begin
        dv[g+1] <= dv[g];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        ds[g+1] <= ds_next[g];
      end
    end
  end

  // Final stage: signed offset, viewport shift and clamping to 32 bits.
  function automatic logic [WORD_W-1:0] clamp(input logic signed [RES_W-1:0] v);
    logic [WORD_W-1:0] c;
    if (v > $signed(RES_W'(32'h7FFF_FFFF))) begin
      c = 32'h7FFF_FFFF;
    end else if (v < -$signed(RES_W'(32'h8000_0000))) begin
      c = 32'h8000_0000;
    end else begin
      c = v[WORD_W-1:0];
    end
    return c;
  endfunction

  always_comb begin
    logic signed [OFF_W-1:0] mag_x, mag_y, off_x, off_y;
    logic signed [RES_W-1:0] hw, hh;
    div_t f;
    f     = ds[DIV_STAGES];
    mag_x = f.sat_x ? OFF_W'(1) <<< Q_W : OFF_W'(f.quo_x);
    mag_y = f.sat_y ? OFF_W'(1) <<< Q_W : OFF_W'(f.quo_y);
    off_x = f.neg_x ? -mag_x : mag_x;
    off_y = f.neg_y ? -mag_y : mag_y;
    hw    = $signed(RES_W'(scale_x));
    hh    = $signed(RES_W'(scale_y));
    res.visible  = f.vis;
    res.screen_x = f.vis ? clamp(hw + RES_W'(off_x)) : '0;
    res.screen_y = f.vis ? clamp(hh - RES_W'(off_y)) : '0;
  end

  // Output register with a skid register behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (result.ready) begin
        skid_valid <= 1'b0;
      end
    end else if (dv[DIV_STAGES]) begin
      if (!out_valid || result.ready) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (result.ready) begin
        out_data <= skid_data;
      end
    end else if (dv[DIV_STAGES]) begin
      if (!out_valid || result.ready) begin
        out_data <= res;
      end else begin
        skid_data <= res;
      end
    end
  end

  assign result.valid    = out_valid;
  assign result.visible  = out_data.visible;
  assign result.screen_x = out_data.screen_x;
  assign result.screen_y = out_data.screen_y;

endmodule

// File: test/tb_top.sv
module tb_top;
  import w2s_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_ITEMS = 1800;

  logic                   clk;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  w2s_in_if  point_ch ();
  w2s_out_if result_ch ();

  world_to_screen_projection dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .point     (point_ch.sink),
    .result    (result_ch.source)
  );

  typedef struct packed {
    logic        vis;
    logic [31:0] sx;
    logic [31:0] sy;
  } screen_pos_t;

  typedef struct {
    logic        op;
    logic [3:0]  idx;
    logic [31:0] coef;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    bit          typed;
    screen_pos_t want;
  } stim_row_t;

  // Shadow copy of the block's state.
  logic [31:0] shadow_matrix [MATRIX_DEPTH];
  logic [14:0] shadow_hw;
  logic [14:0] shadow_hh;
  logic [30:0] shadow_wmin;

  screen_pos_t pending_pos [$];
  int          mismatch_count;
  int          cycle_count;
  bit          out_stall_on;

  always #10 clk = ~clk;

  // Row dot product with floor shift of each product to Q40.24.
  function automatic longint row_dot(int row, logic [31:0] x, logic [31:0] y, logic [31:0] z);
    longint acc;
    acc = (longint'($signed(shadow_matrix[row*4]))   * longint'($signed(x))) >>> 8;
    acc += (longint'($signed(shadow_matrix[row*4+1])) * longint'($signed(y))) >>> 8;
    acc += (longint'($signed(shadow_matrix[row*4+2])) * longint'($signed(z))) >>> 8;
    acc += longint'($signed(shadow_matrix[row*4+3]));
    return acc;
  endfunction

  // Signed offset term, truncated in magnitude and held at 2^40.
  function automatic longint offset_term(longint clip, longint w, longint scale);
    logic [127:0] num;
    logic [127:0] quo;
    logic [63:0]  mag;
    mag = clip < 0 ? 64'(-clip) : 64'(clip);
    num = 128'(mag) * 128'(scale);
    quo = num / 128'(w);
    if (quo >= (128'd1 << 40)) quo = 128'd1 << 40;
    return clip < 0 ? -longint'(quo[63:0]) : longint'(quo[63:0]);
  endfunction

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic screen_pos_t project_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    screen_pos_t p;
    longint w, hw, hh;
    p = '0;
    w = row_dot(2, x, y, z);
    if (w < longint'(shadow_wmin) || w <= 0) return p;
    hw = longint'(shadow_hw) * 256;
    hh = longint'(shadow_hh) * 256;
    p.vis = 1'b1;
    p.sx = clamp32(hw + offset_term(row_dot(0, x, y, z), w, hw));
    p.sy = clamp32(hh - offset_term(row_dot(1, x, y, z), w, hh));
    return p;
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 9) < 5) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      CFG_HALF_WIDTH:  shadow_hw   = value[14:0];
      CFG_HALF_HEIGHT: shadow_hh   = value[14:0];
      CFG_W_MIN:       shadow_wmin = value[30:0];
      default: ;
    endcase
  endtask

  // Drive one transaction; the predictor updates at acceptance. Valid stays high
  // into the next transaction when there is no gap.
  task automatic send_item(stim_row_t r);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      point_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    point_ch.valid      <= 1'b1;
    point_ch.op         <= r.op;
    point_ch.coef_index <= r.idx;
    point_ch.coef_value <= r.coef;
    point_ch.point_x    <= r.px;
    point_ch.point_y    <= r.py;
    point_ch.point_z    <= r.pz;
    do @(posedge clk); while (!point_ch.ready);
    if (r.op == OP_LOAD) begin
      if (r.idx < MATRIX_DEPTH) shadow_matrix[r.idx] = r.coef;
    end else begin
      pending_pos.push_back(r.typed ? r.want : project_point(r.px, r.py, r.pz));
    end
    @(negedge clk);
  endtask

  task automatic drain();
    point_ch.valid <= 1'b0;
    while (pending_pos.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic stim_row_t load_row(int idx, logic [31:0] value);
    stim_row_t r;
    r = '{op: OP_LOAD, idx: 4'(idx), coef: value, px: $urandom, py: $urandom, pz: $urandom,
          typed: 0, want: '0};
    return r;
  endfunction

  function automatic stim_row_t proj_row(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                         bit typed, screen_pos_t want);
    stim_row_t r;
    r = '{op: OP_PROJECT, idx: 4'($urandom), coef: $urandom, px: x, py: y, pz: z,
          typed: typed, want: want};
    return r;
  endfunction

  // A matrix of random scale with a w row kept mostly positive.
  function automatic logic [31:0] rand_coef(int idx);
    case ($urandom_range(0, 7))
      0: return $urandom;
      1: return 32'h80000000;
      2: return 32'h7fffffff;
      default: begin
        if (idx >= 8 && idx != 11) return $urandom_range(0, 32'h0200_0000) - 32'h0040_0000;
        if (idx == 11) return $urandom_range(32'h0010_0000, 32'h0400_0000);
        return $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
      end
    endcase
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return $urandom_range(0, 32'h0000_4000) - 32'h0000_2000;
    endcase
  endfunction

  // Result checking against the oldest expectation.
  always @(posedge clk) begin
    screen_pos_t want;
    cycle_count <= cycle_count + 1;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_pos.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result transaction");
      end else begin
        want = pending_pos.pop_front();
        if (want.vis !== result_ch.visible || want.sx !== result_ch.screen_x ||
            want.sy !== result_ch.screen_y) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected vis=%0d x=%h y=%h, got vis=%0d x=%h y=%h",
                     want.vis, want.sx, want.sy, result_ch.visible,
                     result_ch.screen_x, result_ch.screen_y);
        end
      end
    end
  end

  // Result-side stalls, with quiet stretches between bursts.
  always @(negedge clk) begin
    if ($urandom_range(0, 299) == 0) out_stall_on <= ~out_stall_on;
    result_ch.ready <= out_stall_on ? ($urandom_range(0, 9) < 6) : 1'b1;
  end

  always @(posedge clk) begin
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[world_to_screen_projection] ERROR");
      $finish;
    end
  end

  initial begin
    stim_row_t   table_rows [$];
    screen_pos_t blank;
    int          phase;
    clk = 1'b0;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    point_ch.valid = 1'b0;
    point_ch.op = OP_LOAD;
    point_ch.coef_index = '0;
    point_ch.coef_value = '0;
    point_ch.point_x = '0;
    point_ch.point_y = '0;
    point_ch.point_z = '0;
    result_ch.ready = 1'b1;
    out_stall_on = 1'b0;
    mismatch_count = 0;
    cycle_count = 0;
    foreach (shadow_matrix[i]) shadow_matrix[i] = '0;
    shadow_hw = HALF_WIDTH_RESET;
    shadow_hh = HALF_HEIGHT_RESET;
    shadow_wmin = W_MIN_RESET;
    blank = '0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed table: a cleared matrix gives w of zero, so nothing is visible.
    table_rows.push_back(proj_row(32'h7fffffff, 32'h80000000, 32'h0, 1, blank));
    table_rows.push_back(proj_row(32'h0, 32'h0, 32'h0, 1, blank));
    // Loads beyond the matrix are ignored.
    for (int i = 12; i < 16; i++) table_rows.push_back(load_row(i, 32'hffffffff));
    table_rows.push_back(proj_row(32'h100, 32'h100, 32'h100, 1, blank));
    // Identity-like matrix with w = z.
    table_rows.push_back(load_row(0, 32'h0100_0000));
    table_rows.push_back(load_row(5, 32'h0100_0000));
    table_rows.push_back(load_row(10, 32'h0100_0000));
    // Centre of the screen for a point on the axis at z = 1.
    table_rows.push_back(proj_row(32'h0, 32'h0, 32'h100, 1,
                                  '{1'b1, 32'(960 * 256), 32'(540 * 256)}));
    // Behind the viewer and just below w_min.
    table_rows.push_back(proj_row(32'h0, 32'h0, 32'hffffff00, 1, blank));
    table_rows.push_back(proj_row(32'h100, 32'h100, 32'h0000_0019, 1, blank));
    // Extremes of the coordinates, saturating both ways.
    table_rows.push_back(proj_row(32'h7fffffff, 32'h80000000, 32'h0000_001a, 0, blank));
    table_rows.push_back(proj_row(32'h80000000, 32'h7fffffff, 32'h0000_001a, 0, blank));
    table_rows.push_back(proj_row(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, blank));
    table_rows.push_back(load_row(3, 32'h7fffffff));
    table_rows.push_back(load_row(7, 32'h80000000));
    table_rows.push_back(load_row(11, 32'h7fffffff));
    table_rows.push_back(proj_row(32'h80000000, 32'h80000000, 32'h80000000, 0, blank));
    table_rows.push_back(proj_row(32'h0000_0080, 32'hffff_ff80, 32'h0, 0, blank));
    foreach (table_rows[i]) send_item(table_rows[i]);
    drain();

    // Zero w with w_min of zero, and extreme register settings.
    write_reg(CFG_W_MIN, '0);
    write_reg(CFG_HALF_WIDTH, 31'h7fff);
    write_reg(CFG_HALF_HEIGHT, 31'h0);
    send_item(load_row(11, 32'h0));
    send_item(proj_row(32'h0, 32'h0, 32'h0, 1, blank));
    send_item(proj_row(32'h123, 32'h456, 32'h100, 0, blank));
    drain();

    // Random phases, each with its own register settings.
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          write_reg(CFG_HALF_WIDTH, 31'd960);
          write_reg(CFG_HALF_HEIGHT, 31'd540);
          write_reg(CFG_W_MIN, 31'd1677722);
        end
        1: begin
          write_reg(CFG_HALF_WIDTH, 31'h7fff);
          write_reg(CFG_HALF_HEIGHT, 31'h7fff);
          write_reg(CFG_W_MIN, 31'h7fffffff);
        end
        2: begin
          write_reg(CFG_HALF_WIDTH, 31'd0);
          write_reg(CFG_HALF_HEIGHT, 31'd0);
          write_reg(CFG_W_MIN, 31'd0);
        end
        default: begin
          write_reg(CFG_HALF_WIDTH, CFG_DATA_W'($urandom));
          write_reg(CFG_HALF_HEIGHT, CFG_DATA_W'($urandom));
          write_reg(CFG_W_MIN, $urandom_range(0, 3) == 0 ? CFG_DATA_W'($urandom)
                                                         : CFG_DATA_W'($urandom_range(0, 1 << 24)));
        end
      endcase
      for (int n = 0; n < RANDOM_ITEMS / 6; n++) begin
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 2) begin
          int ix;
          ix = $urandom_range(0, 15);
          send_item(load_row(ix, rand_coef(ix)));
        end else begin
          send_item(proj_row(rand_coord(), rand_coord(), rand_coord(), 0, blank));
        end
      end
      drain();
    end

    if (mismatch_count == 0 && pending_pos.size() == 0) begin
      $display("[world_to_screen_projection] OK");
    end else begin
      $display("[world_to_screen_projection] ERROR");
    end
    $finish;
  end

endmodule
